>>> sv/expression_to_register_code_top_macros.svh
// assertion macros for the expression to register code block
// used by the port checker; no other dependencies
`ifndef EXPRESSION_TO_REGISTER_CODE_TOP_MACROS_SVH
`define EXPRESSION_TO_REGISTER_CODE_TOP_MACROS_SVH

// same-cycle implication
`define ETRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/etrc_pkg.sv
// shared types and codes for the expression to register code block
// no dependencies
`default_nettype none

package etrc_pkg;

	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_ADD    = 3'd1;
	localparam logic [2:0] KIND_SUB    = 3'd2;
	localparam logic [2:0] KIND_MUL    = 3'd3;
	localparam logic [2:0] KIND_DIV    = 3'd4;
	localparam logic [2:0] KIND_ACCEPT = 3'd5;
	localparam logic [2:0] KIND_ERROR  = 3'd6;

	localparam int BATCH_MAX = 4;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] dest_reg;
		logic [4:0] src_reg;
		logic [9:0] immediate;
		logic [5:0] error_pos;
		logic       expected_class;
		logic [7:0] received;
	} res_t;

	typedef struct packed {
		logic [2:0]                 count;
		res_t [BATCH_MAX-1:0]       items;
	} batch_t;

endpackage

`default_nettype wire

>>> sv/etrc_core.sv
// parser state and per-character instruction generation
// depends on etrc_pkg
`default_nettype none

module etrc_core #(
	parameter int REG_LIMIT  = 32,
	parameter int MAX_LEN    = 64,
	parameter int MAX_DIGITS = 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      char_code,
	input  wire logic            first,
	output etrc_pkg::batch_t     batch
);

	localparam int RW  = $clog2(REG_LIMIT);
	localparam int NUW = $clog2(REG_LIMIT + 1);
	localparam int PW  = $clog2(MAX_LEN + 1);
	localparam int STK = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	typedef enum logic [1:0] {PH_NUMBER, PH_DIGITS, PH_AFTER} phase_t;
	typedef enum logic [1:0] {PEND_NONE, PEND_ONE, PEND_TWO} pend_t;

	phase_t           phase_q, e_phase, n_phase;
	logic [1:0]       dcnt_q, e_dcnt, n_dcnt;
	logic [9:0]       vacc_q, e_vacc, n_vacc;
	pend_t            pmul_q, e_pmul, n_pmul;
	pend_t            padd_q, e_padd, n_padd;
	logic [PW-1:0]    pos_q, e_pos, n_pos;
	logic [RW-1:0]    addl_q, n_addl;
	logic [RW-1:0]    term_q, n_term;
	logic [RW-1:0]    free_q [STK];
	logic [RW-1:0]    n_free [STK];
	logic [2:0]       ftop_q, e_ftop, n_ftop;
	logic [NUW-1:0]   nu_q, e_nu, n_nu;
	logic             fin_q, e_fin, n_fin;

	logic             is_digit;
	logic [3:0]       dval;
	logic             do_end, do_op, fail_req, fail_cls;
	logic [RW-1:0]    r_new, r_final;
	logic [2:0]       cnt;
	etrc_pkg::batch_t b;

	function automatic etrc_pkg::res_t mk_res(input logic [2:0] kind, input logic [4:0] dst,
			input logic [4:0] src, input logic [9:0] imm, input logic [5:0] epos,
			input logic ecls, input logic [7:0] recv);
		etrc_pkg::res_t r;
		r.kind           = kind;
		r.dest_reg       = dst;
		r.src_reg        = src;
		r.immediate      = imm;
		r.error_pos      = epos;
		r.expected_class = ecls;
		r.received       = recv;
		return r;
	endfunction

	always_comb begin
		e_phase = first ? PH_NUMBER : phase_q;
		e_dcnt  = first ? 2'd0 : dcnt_q;
		e_vacc  = first ? 10'd0 : vacc_q;
		e_pmul  = first ? PEND_NONE : pmul_q;
		e_padd  = first ? PEND_NONE : padd_q;
		e_pos   = first ? '0 : pos_q;
		e_ftop  = first ? 3'd0 : ftop_q;
		e_nu    = first ? '0 : nu_q;
		e_fin   = first ? 1'b0 : fin_q;

		n_phase = e_phase;
		n_dcnt  = e_dcnt;
		n_vacc  = e_vacc;
		n_pmul  = e_pmul;
		n_padd  = e_padd;
		n_pos   = e_pos;
		n_addl  = addl_q;
		n_term  = term_q;
		n_free  = free_q;
		n_ftop  = e_ftop;
		n_nu    = e_nu;
		n_fin   = e_fin;

		is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		dval     = 4'(char_code - CH_ZERO);
		do_end   = 1'b0;
		do_op    = 1'b0;
		fail_req = 1'b0;
		fail_cls = 1'b0;
		r_new    = '0;
		r_final  = '0;
		cnt      = 3'd0;
		b        = '0;

		if (!e_fin) begin
			if (e_pos >= PW'(MAX_LEN - 1) && char_code != CH_NUL) begin
				fail_req = 1'b1;
				fail_cls = 1'b1;
			end else begin
				unique case (e_phase)
					PH_NUMBER: begin
						if (is_digit) begin
							n_vacc  = 10'(dval);
							n_dcnt  = 2'd1;
							n_phase = PH_DIGITS;
							do_end  = (MAX_DIGITS <= 1);
						end else begin
							fail_req = 1'b1;
							fail_cls = 1'b0;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							n_vacc = 10'({e_vacc, 3'b000}) + 10'({e_vacc, 1'b0}) + 10'(dval);
							n_dcnt = e_dcnt + 2'd1;
							do_end = (n_dcnt >= 2'(MAX_DIGITS));
						end else begin
							do_end = 1'b1;
							do_op  = 1'b1;
						end
					end
					PH_AFTER: do_op = 1'b1;
					default: ;
				endcase
			end

			// close the number: load it, then fold a pending multiply or divide
			if (do_end) begin
				if (n_ftop != 3'd0) begin
					n_ftop = n_ftop - 3'd1;
					r_new  = n_free[n_ftop[1:0]];
				end else if (n_nu >= NUW'(REG_LIMIT)) begin
					r_new = RW'(REG_LIMIT - 1);
				end else begin
					r_new = n_nu[RW-1:0];
					n_nu  = n_nu + NUW'(1);
				end
				b.items[cnt[1:0]] = mk_res(etrc_pkg::KIND_LOAD, 5'(r_new), 5'd0, n_vacc,
					6'd0, 1'b0, 8'd0);
				cnt = cnt + 3'd1;
				if (n_pmul != PEND_NONE) begin
					b.items[cnt[1:0]] = mk_res((n_pmul == PEND_ONE) ? etrc_pkg::KIND_MUL :
						etrc_pkg::KIND_DIV, 5'(n_term), 5'(r_new), 10'd0, 6'd0, 1'b0, 8'd0);
					cnt = cnt + 3'd1;
					if (!n_ftop[2]) begin
						n_free[n_ftop[1:0]] = r_new;
						n_ftop = n_ftop + 3'd1;
					end
				end else begin
					n_term = r_new;
				end
				n_pmul  = PEND_NONE;
				n_phase = PH_AFTER;
				n_dcnt  = 2'd0;
				n_vacc  = 10'd0;
			end

			if (do_op) begin
				if (char_code == CH_STAR || char_code == CH_SLASH) begin
					n_pmul  = (char_code == CH_STAR) ? PEND_ONE : PEND_TWO;
					n_phase = PH_NUMBER;
				end else if (char_code == CH_PLUS || char_code == CH_MINUS ||
						char_code == CH_NUL) begin
					r_final = n_term;
					if (n_padd != PEND_NONE) begin
						b.items[cnt[1:0]] = mk_res((n_padd == PEND_ONE) ? etrc_pkg::KIND_ADD :
							etrc_pkg::KIND_SUB, 5'(n_addl), 5'(n_term), 10'd0, 6'd0, 1'b0, 8'd0);
						cnt = cnt + 3'd1;
						if (!n_ftop[2]) begin
							n_free[n_ftop[1:0]] = n_term;
							n_ftop = n_ftop + 3'd1;
						end
						r_final = n_addl;
					end else begin
						n_addl = n_term;
					end
					if (char_code == CH_NUL) begin
						n_padd = PEND_NONE;
						b.items[cnt[1:0]] = mk_res(etrc_pkg::KIND_ACCEPT, 5'(r_final), 5'd0,
							10'd0, 6'd0, 1'b0, 8'd0);
						cnt   = cnt + 3'd1;
						n_fin = 1'b1;
					end else begin
						n_padd  = (char_code == CH_PLUS) ? PEND_ONE : PEND_TWO;
						n_phase = PH_NUMBER;
					end
				end else begin
					fail_req = 1'b1;
					fail_cls = 1'b1;
				end
			end

			if (fail_req) begin
				b.items[cnt[1:0]] = mk_res(etrc_pkg::KIND_ERROR, 5'd0, 5'd0, 10'd0,
					6'(e_pos), fail_cls, char_code);
				cnt   = cnt + 3'd1;
				n_fin = 1'b1;
			end

			if (e_pos < PW'(MAX_LEN))
				n_pos = e_pos + PW'(1);
		end
		b.count = cnt;
		batch   = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NUMBER;
			dcnt_q  <= 2'd0;
			vacc_q  <= 10'd0;
			pmul_q  <= PEND_NONE;
			padd_q  <= PEND_NONE;
			pos_q   <= '0;
			ftop_q  <= 3'd0;
			nu_q    <= '0;
			fin_q   <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			dcnt_q  <= n_dcnt;
			vacc_q  <= n_vacc;
			pmul_q  <= n_pmul;
			padd_q  <= n_padd;
			pos_q   <= n_pos;
			ftop_q  <= n_ftop;
			nu_q    <= n_nu;
			fin_q   <= n_fin;
		end
	end

	// register numbers, no reset needed
	always_ff @(posedge clk) begin
		if (step) begin
			addl_q <= n_addl;
			term_q <= n_term;
			free_q <= n_free;
		end
	end

endmodule

`default_nettype wire

>>> sv/expression_to_register_code_top.sv
// top level of the expression to register code block
// depends on etrc_pkg and etrc_core
//
// usage: one expression character per input beat on s_*; s_tuser set marks the first
// character of a new expression and clears the parser before that character is parsed.
// each character gives zero to four output beats on m_*: LOAD, ADD, SUB, MUL, DIV,
// then accepted or syntax error; m_tlast marks the final beat caused by one character.
// after accepted or error, characters give no beats until one arrives with s_tuser set.
// a character sits in the input register; parsing loads its beats into the result buffer.
// throughput: one character per cycle while each gives at most one beat and m_tready is
// high; a character with more beats holds the input while the one-beat-per-cycle result
// buffer drains the up to four beats of that character.
// the next character is parsed in the cycle the last buffered beat leaves.
// reset clears the parser and drops buffered beats; while m_tready is low the buffer
// holds its beats and s_tready falls once the input register is also full.
`default_nettype none

module expression_to_register_code_top #(
	parameter int REG_LIMIT  = 32,
	parameter int MAX_LEN    = 64,
	parameter int MAX_DIGITS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_code
	input  wire logic        s_tuser,   // first
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // dest_reg, src_reg, immediate, error_pos,
	                                    // expected_class, received, zero pad
	output logic [2:0]       m_tuser,   // kind
	output logic             m_tlast    // last
);

	localparam int BM = etrc_pkg::BATCH_MAX;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              first_s1;
	logic              room, proc, pop;
	etrc_pkg::batch_t  batch;
	etrc_pkg::res_t    res_q [BM];
	logic [2:0]        cnt_q;

	assign pop      = m_tvalid && m_tready;
	assign room     = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_tready);
	assign proc     = valid_s1 && room;
	assign s_tready = !valid_s1 || proc;

	etrc_core #(
		.REG_LIMIT  (REG_LIMIT),
		.MAX_LEN    (MAX_LEN),
		.MAX_DIGITS (MAX_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (proc),
		.char_code (char_s1),
		.first     (first_s1),
		.batch     (batch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 3'd0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (proc)
				cnt_q <= batch.count;
			else if (pop)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
		if (proc) begin
			for (int i = 0; i < BM; i++)
				res_q[i] <= batch.items[i];
		end else if (pop) begin
			for (int i = 0; i < BM - 1; i++)
				res_q[i] <= res_q[i+1];
		end
	end

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tuser  = res_q[0].kind;
	assign m_tlast  = (cnt_q == 3'd1);
	assign m_tdata  = {5'd0, res_q[0].received, res_q[0].expected_class, res_q[0].error_pos,
		res_q[0].immediate, res_q[0].src_reg, res_q[0].dest_reg};

endmodule

`default_nettype wire

>>> sv/etrc_check.sv
// port checker for the expression to register code block, bound to the top level
// depends on etrc_pkg and expression_to_register_code_top_macros.svh
`default_nettype none

`include "expression_to_register_code_top_macros.svh"

module etrc_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	`ETRC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed while stalled")
	`ETRC_ASSERT_IMP(a_end_last, clk, arst_n, m_tvalid && (m_tuser == etrc_pkg::KIND_ACCEPT || m_tuser == etrc_pkg::KIND_ERROR), m_tlast, "accept or error beat not last")
	`ETRC_ASSERT_IMP(a_load_imm, clk, arst_n, m_tvalid && m_tuser == etrc_pkg::KIND_LOAD, m_tdata[19:10] <= 10'd999, "load constant out of range")
	`ETRC_ASSERT_IMP(a_err_fields, clk, arst_n, m_tvalid && m_tuser != etrc_pkg::KIND_ERROR, m_tdata[34:20] == 15'd0, "error fields set on non-error beat")

endmodule

bind expression_to_register_code_top etrc_check u_check (.*);

`default_nettype wire
